FILE: sv/aes_cmac_tag_generator_unit_assert.svh
// Assertion macros shared by the CMAC RTL
`ifndef AES_CMAC_TAG_GENERATOR_UNIT_ASSERT_SVH
`define AES_CMAC_TAG_GENERATOR_UNIT_ASSERT_SVH

// Implication in the same cycle
`define ACMAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication in the following cycle
`define ACMAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/acmac_pkg.sv
`default_nettype none
package acmac_pkg;

  localparam int BLK_W = 128;
  localparam int NBYTES = 16;
  localparam logic [4:0] CNT_FULL = 5'd16;
  localparam logic [3:0] LAST_RND = 4'd10;

  typedef enum logic [1:0] {
    JOB_CHAIN,
    JOB_TAG,
    JOB_SUBKEY
  } job_t;

  // request into the round engine
  typedef struct packed {
    logic             start;
    job_t             job;
    logic [BLK_W-1:0] blk;
  } eng_req_t;

  // completion from the round engine
  typedef struct packed {
    logic             done;
    job_t             job;
    logic [BLK_W-1:0] blk;
  } eng_rsp_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // one AES round: SubBytes, ShiftRows, MixColumns (skipped in last), AddRoundKey
  function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                 input logic [BLK_W-1:0] rk,
                                                 input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] al;
    logic [BLK_W-1:0] r;
    for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[c*4+i] = b[((c+i) & 3)*4+i];
    for (int c = 0; c < 4; c++) begin
      al = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
      m[c*4]   = t[c*4]   ^ al ^ xtime(t[c*4]   ^ t[c*4+1]);
      m[c*4+1] = t[c*4+1] ^ al ^ xtime(t[c*4+1] ^ t[c*4+2]);
      m[c*4+2] = t[c*4+2] ^ al ^ xtime(t[c*4+2] ^ t[c*4+3]);
      m[c*4+3] = t[c*4+3] ^ al ^ xtime(t[c*4+3] ^ t[c*4]);
    end
    for (int i = 0; i < 16; i++)
      r[127-8*i -: 8] = (last ? t[i] : m[i]) ^ rk[127-8*i -: 8];
    return r;
  endfunction

  // next round key from the previous one
  function automatic logic [BLK_W-1:0] key_next(input logic [BLK_W-1:0] k,
                                                input logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] n0, n1, n2, n3;
    t = {k[23:0], k[31:24]};
    t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]};
    t = t ^ {rc, 24'h0};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  // GF(2^128) doubling with 0x87 reduction
  function automatic logic [BLK_W-1:0] dbl(input logic [BLK_W-1:0] x);
    return {x[126:0], 1'b0} ^ (x[127] ? 128'h87 : 128'h0);
  endfunction

endpackage
`default_nettype wire

FILE: sv/acmac_if.sv
`default_nettype none
// message byte channel
interface acmac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source(output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink(input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

// tag word channel
interface acmac_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag_word;
  logic        tag_done;
  modport source(output valid, tag_word, tag_done, input ready);
  modport sink(input valid, tag_word, tag_done, output ready);
endinterface
`default_nettype wire

FILE: sv/acmac_engine.sv
`default_nettype none
`include "aes_cmac_tag_generator_unit_assert.svh"
module acmac_engine import acmac_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [63:0]      cfg_data,
  input  wire eng_req_t         req,
  input  wire logic             stall,
  output eng_rsp_t              rsp,
  output logic                  busy,
  output logic                  key_busy,
  output logic [BLK_W-1:0]      k1
);

  logic [BLK_W-1:0] key_r;
  logic             kexp_busy_r;
  logic [3:0]       kexp_cnt_r;
  logic [BLK_W-1:0] kcur_r;
  logic [BLK_W-1:0] rk_r [11];
  logic             lreq_r;
  logic             busy_r;
  job_t             job_r;
  logic [3:0]       rnd_r;
  logic [BLK_W-1:0] st_r;
  logic [BLK_W-1:0] k1_r;

  logic [BLK_W-1:0] kn;
  logic [BLK_W-1:0] rk_new;
  logic [BLK_W-1:0] round_out;
  logic             fin;
  logic             done_any;
  logic             launch_l;
  logic             launch_r;

  // key schedule step and round datapath
  always_comb begin
    kn        = key_next(kcur_r, RCON[(kexp_cnt_r == 4'd0) ? 4'd0 : kexp_cnt_r - 4'd1]);
    rk_new    = (kexp_cnt_r == 4'd0) ? key_r : kn;
    round_out = aes_round(st_r, rk_r[rnd_r], rnd_r == LAST_RND);
    fin       = busy_r && (rnd_r == LAST_RND);
    done_any  = fin && !(job_r == JOB_TAG && stall);
    launch_l  = !busy_r && lreq_r;
    launch_r  = !busy_r && !lreq_r && req.start;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      kexp_busy_r <= 1'b1;
      kexp_cnt_r  <= '0;
      lreq_r      <= 1'b0;
      busy_r      <= 1'b0;
      job_r       <= JOB_CHAIN;
      rnd_r       <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index) key_r[63:0] <= cfg_data;
        else key_r[127:64] <= cfg_data;
        kexp_busy_r <= 1'b1;
        kexp_cnt_r  <= '0;
        lreq_r      <= 1'b0;
      end else if (kexp_busy_r) begin
        kexp_cnt_r <= kexp_cnt_r + 4'd1;
        if (kexp_cnt_r == LAST_RND) begin
          kexp_busy_r <= 1'b0;
          lreq_r      <= 1'b1;
        end
      end else if (launch_l) begin
        lreq_r <= 1'b0;
      end
      if (busy_r) begin
        if (rnd_r != LAST_RND) rnd_r <= rnd_r + 4'd1;
        else if (done_any) busy_r <= 1'b0;
      end else if (launch_l || launch_r) begin
        busy_r <= 1'b1;
        job_r  <= launch_l ? JOB_SUBKEY : req.job;
        rnd_r  <= 4'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (kexp_busy_r && !cfg_we) begin
      kcur_r            <= rk_new;
      rk_r[kexp_cnt_r]  <= rk_new;
    end
    if (busy_r) begin
      if (rnd_r != LAST_RND) st_r <= round_out;
      else if (done_any && job_r == JOB_SUBKEY) k1_r <= dbl(round_out);
    end else if (launch_l) begin
      st_r <= rk_r[0];
    end else if (launch_r) begin
      st_r <= req.blk ^ rk_r[0];
    end
  end

  assign rsp.done = done_any && (job_r != JOB_SUBKEY);
  assign rsp.job  = job_r;
  assign rsp.blk  = round_out;
  assign busy     = busy_r;
  assign key_busy = kexp_busy_r || lreq_r || (busy_r && job_r == JOB_SUBKEY);
  assign k1       = k1_r;

  `ACMAC_ASSERT_NOW(a_rnd_range, busy_r, (rnd_r != 4'd0) && (rnd_r <= LAST_RND), "round count out of range")
  `ACMAC_ASSERT_NEXT(a_launch_busy, launch_l || launch_r, busy_r && rnd_r == 4'd1, "engine did not launch")
  `ACMAC_ASSERT_NOW(a_key_idle, kexp_busy_r, !busy_r || job_r != JOB_SUBKEY, "subkey job during expansion")

endmodule
`default_nettype wire

FILE: sv/aes_cmac_tag_generator_unit.sv
// AES-128 CMAC tag generator. Message bytes arrive at most one per beat on in_ch
// and are taken at up to one per cycle; the two 64-bit tag words leave on out_ch,
// upper half first, tag_done set on the lower one. One iterative AES round engine,
// one round per cycle, serves all work; a finished tag holds in its last round
// while the previous tag is still on out_ch. Outside key setup, input stalls only
// when a byte arriving on a full 16-byte buffer must start a chain encryption
// while the engine is still busy, and from a final beat until its tag encryption
// starts, which waits for any pending chain encryption. After reset and after each
// key write the block runs key expansion and the subkey (AES of zero) with in_ch.ready low.
`default_nettype none
`include "aes_cmac_tag_generator_unit_assert.svh"
module aes_cmac_tag_generator_unit import acmac_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  acmac_in_if.sink         in_ch,
  acmac_out_if.source      out_ch
);

  logic [7:0]       buf_r [NBYTES];
  logic [4:0]       cnt_r;
  logic [BLK_W-1:0] chain_r;
  logic             tagq_valid_r;
  logic [BLK_W-1:0] tagq_blk_r;
  logic             out_valid_r;
  logic [63:0]      out_word_r;
  logic             out_done_r;
  logic             lo_pend_r;
  logic [63:0]      lo_word_r;

  eng_req_t         eng_req;
  eng_rsp_t         eng_rsp;
  logic             eng_busy;
  logic             key_busy;
  logic [BLK_W-1:0] k1;

  logic             acc;
  logic             need_chain;
  logic             tag_go;
  logic             tag_fin;
  logic [3:0]       idx;
  logic [4:0]       p;
  logic [BLK_W-1:0] buf_vec;
  logic [BLK_W-1:0] buf_new;
  logic [BLK_W-1:0] pad;
  logic [BLK_W-1:0] fin_blk;

  acmac_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (eng_req),
    .stall    (out_valid_r || lo_pend_r),
    .rsp      (eng_rsp),
    .busy     (eng_busy),
    .key_busy (key_busy),
    .k1       (k1)
  );

  // handshake and job launch
  always_comb begin
    need_chain  = in_ch.has_byte && (cnt_r == CNT_FULL);
    in_ch.ready = !key_busy && !tagq_valid_r && !(eng_busy && need_chain);
    acc         = in_ch.valid && in_ch.ready;
    tag_go      = tagq_valid_r && !eng_busy;
    tag_fin     = eng_rsp.done && (eng_rsp.job == JOB_TAG);
  end

  // final block: byte insert, 10* pad, subkey
  always_comb begin
    idx = (cnt_r == CNT_FULL) ? 4'd0 : cnt_r[3:0];
    p   = in_ch.has_byte ? {1'b0, idx} + 5'd1 : cnt_r;
    for (int j = 0; j < NBYTES; j++) begin
      buf_vec[127-8*j -: 8] = buf_r[j];
      buf_new[127-8*j -: 8] = (in_ch.has_byte && idx == 4'(j)) ? in_ch.data_byte : buf_r[j];
      if (5'(j) < p) pad[127-8*j -: 8] = buf_new[127-8*j -: 8];
      else if (5'(j) == p) pad[127-8*j -: 8] = 8'h80;
      else pad[127-8*j -: 8] = 8'h00;
    end
    fin_blk = (p == CNT_FULL) ? (buf_new ^ k1) : (pad ^ dbl(k1));
    eng_req.start = (acc && need_chain) || tag_go;
    eng_req.job   = (acc && need_chain) ? JOB_CHAIN : JOB_TAG;
    eng_req.blk   = (acc && need_chain) ? (chain_r ^ buf_vec) : (chain_r ^ tagq_blk_r);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      chain_r      <= '0;
      tagq_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_done_r   <= 1'b0;
      lo_pend_r    <= 1'b0;
    end else begin
      if (acc) begin
        if (in_ch.end_of_message) cnt_r <= '0;
        else if (in_ch.has_byte) cnt_r <= {1'b0, idx} + 5'd1;
      end
      if (acc && in_ch.end_of_message) tagq_valid_r <= 1'b1;
      else if (tag_go) tagq_valid_r <= 1'b0;
      if (tag_go) chain_r <= '0;
      else if (eng_rsp.done && eng_rsp.job == JOB_CHAIN) chain_r <= eng_rsp.blk;
      if (tag_fin) begin
        out_valid_r <= 1'b1;
        out_done_r  <= 1'b0;
        lo_pend_r   <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        if (lo_pend_r) begin
          out_done_r <= 1'b1;
          lo_pend_r  <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc && in_ch.has_byte) buf_r[idx] <= in_ch.data_byte;
    if (acc && in_ch.end_of_message) tagq_blk_r <= fin_blk;
    if (tag_fin) begin
      out_word_r <= eng_rsp.blk[127:64];
      lo_word_r  <= eng_rsp.blk[63:0];
    end else if (out_valid_r && out_ch.ready && lo_pend_r) begin
      out_word_r <= lo_word_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.tag_word = out_word_r;
  assign out_ch.tag_done = out_done_r;

  `ACMAC_ASSERT_NOW(a_start_idle, eng_req.start, !eng_busy, "engine started while busy")
  `ACMAC_ASSERT_NOW(a_tag_free, tag_fin, !out_valid_r && !lo_pend_r, "tag over pending output")
  `ACMAC_ASSERT_NOW(a_lo_pend, lo_pend_r, out_valid_r && !out_done_r, "second word without first")
  `ACMAC_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_FULL, "byte count overflow")

endmodule
`default_nettype wire

FILE: bench/acmac_tb_pkg.sv
`timescale 1ns / 100ps
package acmac_tb_pkg;

  // key register indexes on the cfg port
  localparam logic KEY_UPPER_IDX = 1'b0;
  localparam logic KEY_LOWER_IDX = 1'b1;

  // one tag word as it should leave the block
  typedef struct {
    logic [63:0] word;
    logic        done;
  } tag_beat_t;

endpackage

FILE: bench/tag_checker.sv
`timescale 1ns / 100ps
module tag_checker import acmac_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  acmac_in_if         in_mon,
  acmac_out_if        out_mon,
  output int          fail_count,
  output int          tags_pending
);

  logic [63:0]  key_hi, key_lo;
  logic [127:0] round_key [11];
  logic [127:0] subkey1;
  logic [127:0] chain;
  logic [7:0]   blk [16];
  int           held;
  tag_beat_t    tag_q [$];

  initial fail_count = 0;

  task automatic report_mismatch(input string msg);
    $display("checker: %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return (x << 1) ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] gf_shift(input logic [127:0] x);
    logic [127:0] r;
    r = x << 1;
    if (x[127]) r[7:0] = r[7:0] ^ 8'h87;
    return r;
  endfunction

  function automatic logic [127:0] pack_block();
    logic [127:0] r;
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = blk[i];
    return r;
  endfunction

  // full AES-128 encryption under the current round keys
  function automatic logic [127:0] cipher(input logic [127:0] pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, mix;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ round_key[0][127-8*i -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[c*4+i] = acmac_pkg::SBOX[s[((c+i) % 4)*4+i]];
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        if (rnd < 10) begin
          mix = a0 ^ a1 ^ a2 ^ a3;
          s[c*4]   = a0 ^ mix ^ gmul2(a0 ^ a1);
          s[c*4+1] = a1 ^ mix ^ gmul2(a1 ^ a2);
          s[c*4+2] = a2 ^ mix ^ gmul2(a2 ^ a3);
          s[c*4+3] = a3 ^ mix ^ gmul2(a3 ^ a0);
        end else begin
          s[c*4] = a0; s[c*4+1] = a1; s[c*4+2] = a2; s[c*4+3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) s[i] = s[i] ^ round_key[rnd][127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = s[i];
    return r;
  endfunction

  // key schedule plus first subkey
  task automatic load_key();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
    w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {acmac_pkg::SBOX[t[31:24]], acmac_pkg::SBOX[t[23:16]],
             acmac_pkg::SBOX[t[15:8]], acmac_pkg::SBOX[t[7:0]]};
        t[31:24] = t[31:24] ^ rc;
        rc = gmul2(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    subkey1 = gf_shift(cipher(128'h0));
  endtask

  always @(posedge clk) begin
    logic [127:0] k, tag;
    tag_beat_t    got;
    if (!rst_n) begin
      key_hi = '0;
      key_lo = '0;
      chain = '0;
      held = 0;
      tag_q.delete();
      load_key();
    end else begin
      // key write
      if (cfg_we) begin
        if (cfg_index == KEY_UPPER_IDX) key_hi = cfg_data;
        else key_lo = cfg_data;
        load_key();
      end
      // message beat
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.has_byte) begin
          if (held >= 16) begin
            chain = cipher(chain ^ pack_block());
            held = 0;
          end
          blk[held] = in_mon.data_byte;
          held++;
        end
        if (in_mon.end_of_message) begin
          k = subkey1;
          if (held < 16) begin
            blk[held] = 8'h80;
            for (int i = held + 1; i < 16; i++) blk[i] = 8'h00;
            k = gf_shift(subkey1);
          end
          tag = cipher(pack_block() ^ k ^ chain);
          tag_q.push_back('{word: tag[127:64], done: 1'b0});
          tag_q.push_back('{word: tag[63:0], done: 1'b1});
          chain = '0;
          held = 0;
        end
      end
      // tag beat
      if (out_mon.valid && out_mon.ready) begin
        if (tag_q.size() == 0) begin
          report_mismatch($sformatf("unexpected tag word %h", out_mon.tag_word));
        end else begin
          got = tag_q.pop_front();
          if (out_mon.tag_word !== got.word)
            report_mismatch($sformatf("tag_word %h, want %h", out_mon.tag_word, got.word));
          if (out_mon.tag_done !== got.done)
            report_mismatch($sformatf("tag_done %b, want %b", out_mon.tag_done, got.done));
        end
      end
    end
    tags_pending <= tag_q.size();
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
module testbench import acmac_tb_pkg::*;;

  localparam int ITEM_GOAL  = 1250;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE     = 40;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [63:0] cfg_data;
  int          fail_count;
  int          tags_pending;
  int          in_idle_pct;
  int          out_stall_pct;
  int          items_sent;
  int          quiet_cycles;

  acmac_in_if  in_ch();
  acmac_out_if out_ch();

  aes_cmac_tag_generator_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  tag_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .tags_pending(tags_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one beat on the message channel, with random sender gaps
  task automatic send_beat(input logic [7:0] b, input logic has, input logic eom);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.has_byte       <= has;
    in_ch.end_of_message <= eom;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (has || eom) items_sent++;
  endtask

  // message of len bytes; the end comes on the last byte or on its own beat
  task automatic send_message(input int len, input bit separate_end, input int idle_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < idle_pct) send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(255)), 1'b1, (i == len - 1) && !separate_end);
    end
    if (len == 0 || separate_end) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // key write once the block has drained
  task automatic write_key(input logic idx, input logic [63:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tags_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int target);
    int len;
    while (items_sent < target) begin
      case ($urandom_range(9))
        0:       len = 0;
        1, 2:    len = 16 * $urandom_range(1, 3);
        3:       len = $urandom_range(49, 80);
        default: len = $urandom_range(1, 40);
      endcase
      send_message(len, $urandom_range(3) == 0, 5);
    end
  endtask

  initial begin
    int wait_cycles;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = KEY_UPPER_IDX;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.has_byte = 1'b0;
    in_ch.end_of_message = 1'b0;
    out_ch.ready = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    items_sent = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset key (all zero), edge lengths and special ends
    send_message(0, 1'b0, 0);
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    for (int i = 0; i < 16; i++) send_beat(8'hff, 1'b1, i == 15);
    send_message(17, 1'b1, 0);
    write_key(KEY_UPPER_IDX, '1);
    write_key(KEY_LOWER_IDX, '1);
    send_message(0, 1'b0, 0);
    send_message(16, 1'b1, 0);
    send_message(3, 1'b1, 0);

    // random phases under different key values and flow patterns
    for (int ph = 0; ph < 4; ph++) begin
      write_key(KEY_UPPER_IDX, {$urandom, $urandom});
      write_key(KEY_LOWER_IDX, {$urandom, $urandom});
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 53; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 53; end
        default: begin in_idle_pct = 23; out_stall_pct = 23; end
      endcase
      random_phase(items_sent + ITEM_GOAL / 4);
    end
    write_key(KEY_UPPER_IDX, '0);
    write_key(KEY_LOWER_IDX, 64'h0123456789abcdef);
    send_message(33, 1'b0, 0);
    in_ch.valid <= 1'b0;

    // drain
    wait_cycles = 0;
    while (tags_pending != 0 && wait_cycles < STALL_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && tags_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/acmac_pkg.sv
sv/acmac_if.sv
sv/acmac_engine.sv
sv/aes_cmac_tag_generator_unit.sv
bench/acmac_tb_pkg.sv
bench/tag_checker.sv
bench/testbench.sv
